// File: src/psd_pkg.sv
// shared constants and types of the point to segment distance block
package psd_pkg;

  localparam int unsigned COORD_BITS      = 24;
  localparam int unsigned PARAM_FRAC_BITS = 16;

  // valid bit of the item entering a pipeline and the common advance enable
  typedef struct packed {
    logic valid;
    logic en;
  } pipe_ctrl_t;

endpackage

// File: src/psd_if.sv
// item channels of the point to segment distance block
interface psd_in_if #(
  parameter int unsigned COORD_BITS = psd_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic signed [COORD_BITS-1:0] a_z;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic signed [COORD_BITS-1:0] b_z;
  logic signed [COORD_BITS-1:0] p_x;
  logic signed [COORD_BITS-1:0] p_y;
  logic signed [COORD_BITS-1:0] p_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, p_x, p_y, p_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, p_x, p_y, p_z,
    output ready
  );
endinterface

interface psd_out_if #(
  parameter int unsigned COORD_BITS      = psd_pkg::COORD_BITS,
  parameter int unsigned PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS
);
  logic                       valid;
  logic                       ready;
  logic [PARAM_FRAC_BITS:0]   seg_param;
  logic [COORD_BITS:0]        distance;
  logic                       degenerate;

  modport source (
    output valid, seg_param, distance, degenerate,
    input  ready
  );
  modport sink (
    input  valid, seg_param, distance, degenerate,
    output ready
  );
endinterface

// File: src/point_segment_distance_3d.sv
// throughput: one item per cycle while the output is not stalled; the pipeline is a
// chain of one bit per stage dividers and a one bit per stage square root, all on
// one shared advance enable; a stalled output freezes every stage, so nothing is
// lost or repeated
// reset: asynchronous, active low, clears only the valid bits of each stage
// top level of the point to segment distance block
module point_segment_distance_3d #(
  parameter int unsigned COORD_BITS      = psd_pkg::COORD_BITS,
  parameter int unsigned PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psd_in_if.sink    in_i,
  psd_out_if.source out_o
);

  // widths: differences, products, sums of squares, dot, cross parts
  localparam int unsigned DW   = COORD_BITS + 1;       // signed difference
  localparam int unsigned PW   = 2 * DW;               // signed product
  localparam int unsigned SQW  = 2 * COORD_BITS + 2;   // sum of three squares
  localparam int unsigned DOTW = 2 * COORD_BITS + 3;   // signed dot product
  localparam int unsigned CW   = 2 * COORD_BITS + 1;   // cross component magnitude
  localparam int unsigned HW   = COORD_BITS + 1;       // low half of a cross component
  localparam int unsigned HIW  = CW - HW;              // high half
  localparam int unsigned CSW  = 2 * CW;               // squared cross component
  localparam int unsigned XW   = 4 * COORD_BITS + 4;   // summed squared cross
  localparam int unsigned RW   = COORD_BITS + 1;       // distance
  localparam int unsigned QW   = 2 * RW;               // squared distance
  localparam int unsigned TSW  = XW + SQW + 2;         // side data of the position divider
  localparam int unsigned XSW  = PARAM_FRAC_BITS + 2;  // side data after it

  psd_pkg::pipe_ctrl_t ctrl_div_t, ctrl_div_x, ctrl_sqrt;

  logic en;
  logic out_valid_q;

  // the whole pipeline moves whenever the output register is free or taken
  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // stage 1: coordinate differences d = b - a, v = x - a, w = x - b
  logic signed [DW-1:0] d_q [3];
  logic signed [DW-1:0] v_q [3];
  logic signed [DW-1:0] w_q [3];
  logic signed [DW-1:0] d_d [3];
  logic signed [DW-1:0] v_d [3];
  logic signed [DW-1:0] w_d [3];
  logic                 vld1_q;

  always_comb begin
    d_d[0] = DW'(in_i.b_x) - DW'(in_i.a_x);
    d_d[1] = DW'(in_i.b_y) - DW'(in_i.a_y);
    d_d[2] = DW'(in_i.b_z) - DW'(in_i.a_z);
    v_d[0] = DW'(in_i.p_x) - DW'(in_i.a_x);
    v_d[1] = DW'(in_i.p_y) - DW'(in_i.a_y);
    v_d[2] = DW'(in_i.p_z) - DW'(in_i.a_z);
    w_d[0] = DW'(in_i.p_x) - DW'(in_i.b_x);
    w_d[1] = DW'(in_i.p_y) - DW'(in_i.b_y);
    w_d[2] = DW'(in_i.p_z) - DW'(in_i.b_z);
  end

  // stage 2: squares, dot terms and cross terms of the differences
  logic signed [PW-1:0] dd_q [3];
  logic signed [PW-1:0] vv_q [3];
  logic signed [PW-1:0] ww_q [3];
  logic signed [PW-1:0] vd_q [3];
  logic signed [PW-1:0] cp_q [3];  // v_j * d_k
  logic signed [PW-1:0] cn_q [3];  // v_k * d_j
  logic                 vld2_q;

  // stage 3: length squared, distances squared to both ends, dot, cross parts
  logic [SQW-1:0]         len2_q, sv_q, sw_q;
  logic signed [DOTW-1:0] dot_q;
  logic [CW-1:0]          cm_q [3];
  logic                   vld3_q;

  // stage 4: case split and partial products of the squared cross parts
  logic [2*HIW-1:0]    hh_q [3];
  logic [HIW+HW-1:0]   hl_q [3];
  logic [2*HW-1:0]     ll_q [3];
  logic [SQW-1:0]      len2_4_q, sv_4_q, sw_4_q, dp_4_q;
  logic                degen_4_q, inner_4_q, past_4_q;
  logic                vld4_q;

  // stage 5: squared cross parts
  logic [CSW-1:0]      csq_q [3];
  logic [SQW-1:0]      len2_5_q, sv_5_q, sw_5_q, dp_5_q;
  logic                degen_5_q, inner_5_q, past_5_q;
  logic                vld5_q;

  // stage 6: divider operands
  logic [SQW-1:0]      tnum_q, tden_q, xden_q;
  logic [XW-1:0]       xnum_q;
  logic                degen_6_q, past_6_q;
  logic                vld6_q;

  for (genvar i = 0; i < 3; i++) begin : g_comp
    localparam int unsigned J = (i + 1) % 3;
    localparam int unsigned K = (i + 2) % 3;
    logic signed [PW:0] c_d;
    logic [PW:0]        cabs;

    always_comb begin
      c_d  = (PW+1)'(cp_q[i]) - (PW+1)'(cn_q[i]);
      cabs = c_d[PW] ? -c_d : c_d;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_q[i]  <= d_d[i];
        v_q[i]  <= v_d[i];
        w_q[i]  <= w_d[i];
        dd_q[i] <= PW'(d_q[i]) * PW'(d_q[i]);
        vv_q[i] <= PW'(v_q[i]) * PW'(v_q[i]);
        ww_q[i] <= PW'(w_q[i]) * PW'(w_q[i]);
        vd_q[i] <= PW'(v_q[i]) * PW'(d_q[i]);
        cp_q[i] <= PW'(v_q[J]) * PW'(d_q[K]);
        cn_q[i] <= PW'(v_q[K]) * PW'(d_q[J]);
        cm_q[i] <= cabs[CW-1:0];
        hh_q[i] <= (2*HIW)'(cm_q[i][CW-1:HW]) * (2*HIW)'(cm_q[i][CW-1:HW]);
        hl_q[i] <= (HIW+HW)'(cm_q[i][CW-1:HW]) * (HIW+HW)'(cm_q[i][HW-1:0]);
        ll_q[i] <= (2*HW)'(cm_q[i][HW-1:0]) * (2*HW)'(cm_q[i][HW-1:0]);
        csq_q[i] <= (CSW'(hh_q[i]) << (2*HW)) + (CSW'(hl_q[i]) << (HW+1))
                  + CSW'(ll_q[i]);
      end
    end
  end

  // stage 4 decisions
  logic before_d, past_d, degen_d, inner_d;

  always_comb begin
    degen_d  = (len2_q == '0);
    before_d = dot_q[DOTW-1] || (dot_q == '0);
    // a positive dot fits in the width of the squared length
    past_d   = !degen_d && !before_d && (dot_q[SQW-1:0] >= len2_q);
    inner_d  = !degen_d && !before_d && !past_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      len2_q    <= SQW'(dd_q[0]) + SQW'(dd_q[1]) + SQW'(dd_q[2]);
      sv_q      <= SQW'(vv_q[0]) + SQW'(vv_q[1]) + SQW'(vv_q[2]);
      sw_q      <= SQW'(ww_q[0]) + SQW'(ww_q[1]) + SQW'(ww_q[2]);
      dot_q     <= DOTW'(vd_q[0]) + DOTW'(vd_q[1]) + DOTW'(vd_q[2]);

      len2_4_q  <= len2_q;
      sv_4_q    <= sv_q;
      sw_4_q    <= sw_q;
      dp_4_q    <= dot_q[SQW-1:0];
      degen_4_q <= degen_d;
      inner_4_q <= inner_d;
      past_4_q  <= past_d;

      len2_5_q  <= len2_4_q;
      sv_5_q    <= sv_4_q;
      sw_5_q    <= sw_4_q;
      dp_5_q    <= dp_4_q;
      degen_5_q <= degen_4_q;
      inner_5_q <= inner_4_q;
      past_5_q  <= past_4_q;

      // inside the segment: position dot/len2 and squared distance cross2/len2;
      // at an end or on a point segment the divisor is one and the end distance passes
      tnum_q    <= inner_5_q ? dp_5_q : '0;
      tden_q    <= inner_5_q ? len2_5_q : SQW'(1);
      xden_q    <= inner_5_q ? len2_5_q : SQW'(1);
      if (inner_5_q) begin
        xnum_q <= XW'(csq_q[0]) + XW'(csq_q[1]) + XW'(csq_q[2]);
      end else begin
        xnum_q <= XW'(past_5_q ? sw_5_q : sv_5_q);
      end
      degen_6_q <= degen_5_q;
      past_6_q  <= past_5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_i.valid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
    end
  end

  // position divider, carries the distance operands alongside
  logic [PARAM_FRAC_BITS-1:0] tq;
  logic [TSW-1:0]             tside;
  logic                       tvalid;

  assign ctrl_div_t = '{valid: vld6_q, en: en};

  psd_div #(
    .DEN_BITS  (SQW),
    .QUO_BITS  (PARAM_FRAC_BITS),
    .SIDE_BITS (TSW)
  ) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_div_t),
    .num_i   ({tnum_q, {PARAM_FRAC_BITS{1'b0}}}),
    .den_i   (tden_q),
    .side_i  ({xnum_q, xden_q, past_6_q, degen_6_q}),
    .valid_o (tvalid),
    .quo_o   (tq),
    .side_o  (tside)
  );

  // squared distance divider
  logic [QW-1:0]  xq;
  logic [XSW-1:0] xside;
  logic           xvalid;

  assign ctrl_div_x = '{valid: tvalid, en: en};

  psd_div #(
    .DEN_BITS  (SQW),
    .QUO_BITS  (QW),
    .SIDE_BITS (XSW)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_div_x),
    .num_i   (tside[TSW-1 -: XW]),
    .den_i   (tside[SQW+1:2]),
    .side_i  ({tq, tside[1:0]}),
    .valid_o (xvalid),
    .quo_o   (xq),
    .side_o  (xside)
  );

  // square root of the squared distance
  logic [RW-1:0]  root;
  logic [XSW-1:0] rside;
  logic           rvalid;

  assign ctrl_sqrt = '{valid: xvalid, en: en};

  psd_sqrt #(
    .ROOT_BITS (RW),
    .SIDE_BITS (XSW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_sqrt),
    .rad_i   (xq),
    .side_i  (xside),
    .valid_o (rvalid),
    .root_o  (root),
    .side_o  (rside)
  );

  // output register
  logic [PARAM_FRAC_BITS:0] seg_param_q;
  logic [RW-1:0]            distance_q;
  logic                     degenerate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= rvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // past the end the position is exactly one
      seg_param_q  <= rside[1] ? {1'b1, {PARAM_FRAC_BITS{1'b0}}}
                               : {1'b0, rside[XSW-1:2]};
      distance_q   <= root;
      degenerate_q <= rside[0];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.seg_param  = seg_param_q;
  assign out_o.distance   = distance_q;
  assign out_o.degenerate = degenerate_q;

endmodule

// File: src/psd_div.sv
// pipelined restoring divider, one quotient bit per register stage
module psd_div #(
  parameter int unsigned DEN_BITS  = 50,
  parameter int unsigned QUO_BITS  = 16,
  parameter int unsigned SIDE_BITS = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  psd_pkg::pipe_ctrl_t          ctrl_i,
  input  logic [DEN_BITS+QUO_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0]          den_i,
  input  logic [SIDE_BITS-1:0]         side_i,
  output logic                         valid_o,
  output logic [QUO_BITS-1:0]          quo_o,
  output logic [SIDE_BITS-1:0]         side_o
);

  // numerator must stay below den * 2^QUO_BITS, so the top part starts below den
  logic [DEN_BITS-1:0]  rem_s  [QUO_BITS+1];
  logic [QUO_BITS-1:0]  nq_s   [QUO_BITS+1];
  logic [DEN_BITS-1:0]  den_s  [QUO_BITS+1];
  logic [SIDE_BITS-1:0] side_s [QUO_BITS+1];
  logic                 vld_s  [QUO_BITS+1];

  assign rem_s[0]  = num_i[DEN_BITS+QUO_BITS-1:QUO_BITS];
  assign nq_s[0]   = num_i[QUO_BITS-1:0];
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;
  assign vld_s[0]  = ctrl_i.valid;

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    logic [DEN_BITS:0]    trial;
    logic [DEN_BITS:0]    diff;
    logic                 ge;
    logic [DEN_BITS-1:0]  rem_d, rem_q;
    logic [QUO_BITS-1:0]  nq_d, nq_q;
    logic [DEN_BITS-1:0]  den_q;
    logic [SIDE_BITS-1:0] side_q;
    logic                 vld_q;

    always_comb begin
      trial = {rem_s[k], nq_s[k][QUO_BITS-1]};
      diff  = trial - {1'b0, den_s[k]};
      ge    = (trial >= {1'b0, den_s[k]});
      rem_d = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      // numerator bits leave at the top while quotient bits enter at the bottom
      nq_d  = {nq_s[k][QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        rem_q  <= rem_d;
        nq_q   <= nq_d;
        den_q  <= den_s[k];
        side_q <= side_s[k];
      end
    end

    assign rem_s[k+1]  = rem_q;
    assign nq_s[k+1]   = nq_q;
    assign den_s[k+1]  = den_q;
    assign side_s[k+1] = side_q;
    assign vld_s[k+1]  = vld_q;
  end

  assign valid_o = vld_s[QUO_BITS];
  assign quo_o   = nq_s[QUO_BITS];
  assign side_o  = side_s[QUO_BITS];

endmodule

// File: src/psd_sqrt.sv
// pipelined integer square root, one root bit per register stage, rounded down
module psd_sqrt #(
  parameter int unsigned ROOT_BITS = 25,
  parameter int unsigned SIDE_BITS = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  psd_pkg::pipe_ctrl_t      ctrl_i,
  input  logic [2*ROOT_BITS-1:0]   rad_i,
  input  logic [SIDE_BITS-1:0]     side_i,
  output logic                     valid_o,
  output logic [ROOT_BITS-1:0]     root_o,
  output logic [SIDE_BITS-1:0]     side_o
);

  logic [ROOT_BITS:0]     rem_s  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]   root_s [ROOT_BITS+1];
  logic [2*ROOT_BITS-1:0] rad_s  [ROOT_BITS+1];
  logic [SIDE_BITS-1:0]   side_s [ROOT_BITS+1];
  logic                   vld_s  [ROOT_BITS+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad_i;
  assign side_s[0] = side_i;
  assign vld_s[0]  = ctrl_i.valid;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    logic [ROOT_BITS+2:0]   trial;
    logic [ROOT_BITS+2:0]   sub;
    logic [ROOT_BITS+2:0]   diff;
    logic                   ge;
    logic [ROOT_BITS:0]     rem_d, rem_q;
    logic [ROOT_BITS-1:0]   root_d, root_q;
    logic [2*ROOT_BITS-1:0] rad_q;
    logic [SIDE_BITS-1:0]   side_q;
    logic                   vld_q;

    always_comb begin
      trial  = {rem_s[k], rad_s[k][2*ROOT_BITS-1 -: 2]};
      sub    = {1'b0, root_s[k], 2'b01};
      diff   = trial - sub;
      ge     = (trial >= sub);
      // remainder never exceeds twice the partial root
      rem_d  = ge ? diff[ROOT_BITS:0] : trial[ROOT_BITS:0];
      root_d = {root_s[k][ROOT_BITS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        rad_q  <= {rad_s[k][2*ROOT_BITS-3:0], 2'b00};
        side_q <= side_s[k];
      end
    end

    assign rem_s[k+1]  = rem_q;
    assign root_s[k+1] = root_q;
    assign rad_s[k+1]  = rad_q;
    assign side_s[k+1] = side_q;
    assign vld_s[k+1]  = vld_q;
  end

  assign valid_o = vld_s[ROOT_BITS];
  assign root_o  = root_s[ROOT_BITS];
  assign side_o  = side_s[ROOT_BITS];

endmodule

// File: tb/point_segment_distance_3d_test.sv
// self-checking testbench of the point to segment distance block
module point_segment_distance_3d_test;

  localparam int unsigned COORD_BITS      = psd_pkg::COORD_BITS;
  localparam int unsigned PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS;

  localparam int unsigned PARAM_ONE    = 1 << PARAM_FRAC_BITS;
  localparam longint      DIST_MAX     = (longint'(1) << (COORD_BITS + 1)) - 1;
  localparam int          N_RANDOM     = 750;
  localparam int          DRAIN_CYCLES = 110;   // more than the pipeline depth
  localparam longint      CYCLE_LIMIT  = 400000;
  localparam int          HOLD_AT      = 200;   // accepted items before the long hold-off
  localparam int          HOLD_CYCLES  = 300;   // well past the pipeline depth

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one query: segment A to B and point X
  typedef struct packed {
    coord_t a_x, a_y, a_z;
    coord_t b_x, b_y, b_z;
    coord_t p_x, p_y, p_z;
  } seg_query_t;

  typedef struct packed {
    logic [PARAM_FRAC_BITS:0] seg_param;
    logic [COORD_BITS:0]      distance;
    logic                     degenerate;
  } seg_result_t;

  // directed row, with the result typed in where it is obvious
  typedef struct {
    seg_query_t  q;
    bit          fixed;
    seg_result_t res;
  } seg_row_t;

  logic clk;
  logic rst_n;

  psd_in_if  in_if ();
  psd_out_if out_if ();

  point_segment_distance_3d i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  seg_row_t    directed_rows[$];
  seg_result_t pending_results[$];
  seg_result_t drive_fixed_res;
  bit          drive_fixed;
  int          n_errors;
  int          n_accepted;
  longint      n_cycles;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // floor of the square root, wide enough for any squared distance here
  function automatic longint floor_sqrt(logic [127:0] n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return longint'(r);
  endfunction

  // nearest point on the segment: clamped position and distance
  function automatic seg_result_t nearest_on_segment(seg_query_t q);
    longint       a[3], b[3], x[3], d[3], v[3], w[3];
    longint       len2, dot, vsq, wsq, cr, dist_v;
    logic [127:0] cross2, num;
    seg_result_t  r;
    a = '{longint'(q.a_x), longint'(q.a_y), longint'(q.a_z)};
    b = '{longint'(q.b_x), longint'(q.b_y), longint'(q.b_z)};
    x = '{longint'(q.p_x), longint'(q.p_y), longint'(q.p_z)};
    len2 = 0; dot = 0; vsq = 0; wsq = 0; cross2 = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = b[i] - a[i];
      v[i] = x[i] - a[i];
      w[i] = x[i] - b[i];
      len2 += d[i] * d[i];
      dot  += v[i] * d[i];
      vsq  += v[i] * v[i];
      wsq  += w[i] * w[i];
    end
    r = '0;
    if (len2 == 0) begin
      // zero-length segment, fall back to the distance to A
      r.degenerate = 1'b1;
      dist_v = floor_sqrt(128'(vsq));
    end else if (dot <= 0) begin
      dist_v = floor_sqrt(128'(vsq));
    end else if (dot >= len2) begin
      r.seg_param = PARAM_ONE;
      dist_v = floor_sqrt(128'(wsq));
    end else begin
      num = 128'(dot) << PARAM_FRAC_BITS;
      r.seg_param = (num / 128'(len2));
      for (int i = 0; i < 3; i++) begin
        cr = v[(i + 1) % 3] * d[(i + 2) % 3] - v[(i + 2) % 3] * d[(i + 1) % 3];
        if (cr < 0) cr = -cr;
        cross2 += 128'(cr) * 128'(cr);
      end
      dist_v = floor_sqrt(cross2 / 128'(len2));
    end
    r.distance = (dist_v > DIST_MAX) ? DIST_MAX : dist_v;
    return r;
  endfunction

  task automatic add_row(int ax, int ay, int az, int bx, int by, int bz,
                         int px, int py, int pz, bit fixed = 0,
                         int t = 0, int dist_v = 0, bit degen = 0);
    seg_row_t row;
    row.q = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
              coord_t'(bz), coord_t'(px), coord_t'(py), coord_t'(pz)};
    row.fixed = fixed;
    row.res   = '{seg_param: t, distance: dist_v, degenerate: degen};
    directed_rows.push_back(row);
  endtask

  function automatic coord_t pick_coord(int mode);
    case (mode)
      0:       return coord_t'($urandom);
      1:       return coord_t'($urandom_range(0, 2047)) - 1024;
      2:       return $urandom_range(0, 1) ? coord_t'({1'b0, {(COORD_BITS-1){1'b1}}})
                                            : coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});
      default: return coord_t'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  // full range, small, medium and extreme coordinates, with degenerate and endpoint-near cases mixed in
  function automatic seg_query_t random_query();
    seg_query_t q;
    int         kind;
    int         mode;
    kind = $urandom_range(0, 9);
    mode = (kind <= 3) ? 0 : (kind <= 5) ? 1 : (kind == 8) ? 2 : 3;
    q = '{pick_coord(mode), pick_coord(mode), pick_coord(mode),
          pick_coord(mode), pick_coord(mode), pick_coord(mode),
          pick_coord(mode), pick_coord(mode), pick_coord(mode)};
    if (kind == 6) begin
      q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z;
    end else if (kind == 7) begin
      // point sits near one end of the segment
      if ($urandom_range(0, 1)) begin
        q.p_x = q.a_x + pick_coord(1); q.p_y = q.a_y; q.p_z = q.a_z + pick_coord(1);
      end else begin
        q.p_x = q.b_x; q.p_y = q.b_y + pick_coord(1); q.p_z = q.b_z;
      end
    end
    return q;
  endfunction

  task automatic send_query(seg_query_t q, bit fixed, seg_result_t res);
    in_if.valid <= 1'b1;
    in_if.a_x <= q.a_x; in_if.a_y <= q.a_y; in_if.a_z <= q.a_z;
    in_if.b_x <= q.b_x; in_if.b_y <= q.b_y; in_if.b_z <= q.b_z;
    in_if.p_x <= q.p_x; in_if.p_y <= q.p_y; in_if.p_z <= q.p_z;
    drive_fixed     = fixed;
    drive_fixed_res = res;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // sender idles between bursts of random length
  task automatic maybe_gap(ref int burst_left);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // accepted inputs become expectations, accepted outputs are checked
  always @(posedge clk) begin
    seg_query_t  q;
    seg_result_t got;
    seg_result_t want;
    if (rst_n) begin
      n_cycles <= n_cycles + 1;
      if (in_if.valid && in_if.ready) begin
        q = '{in_if.a_x, in_if.a_y, in_if.a_z, in_if.b_x, in_if.b_y, in_if.b_z,
              in_if.p_x, in_if.p_y, in_if.p_z};
        pending_results.push_back(drive_fixed ? drive_fixed_res : nearest_on_segment(q));
        n_accepted <= n_accepted + 1;
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.seg_param, out_if.distance, out_if.degenerate};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.seg_param !== want.seg_param) begin
            $display("%0t: seg_param expected %0d got %0d", $time, want.seg_param,
                     got.seg_param);
            n_errors++;
          end
          if (got.distance !== want.distance) begin
            $display("%0t: distance expected %0d got %0d", $time, want.distance,
                     got.distance);
            n_errors++;
          end
          if (got.degenerate !== want.degenerate) begin
            $display("%0t: degenerate expected %0b got %0b", $time, want.degenerate,
                     got.degenerate);
            n_errors++;
          end
        end
      end
    end
  end

  // receiver stalls in windows of changing density, with one long hold-off
  always @(negedge clk) begin
    int  hold_left;
    bit  held_once;
    int  window;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!held_once && n_accepted >= HOLD_AT) begin
      held_once = 1;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      window = (n_cycles / 64) % 4;
      case (window)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 3) != 0);
        2:       out_if.ready <= ($urandom_range(0, 1) != 0);
        default: out_if.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (n_cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int       burst_left;
    int       mx;
    int       mn;
    seg_query_t q;
    n_errors    = 0;
    n_accepted  = 0;
    n_cycles    = 0;
    drive_fixed = 0;
    drive_fixed_res = '0;
    burst_left  = 0;
    rst_n       = 1'b0;
    in_if.valid = 1'b0;
    in_if.a_x = '0; in_if.a_y = '0; in_if.a_z = '0;
    in_if.b_x = '0; in_if.b_y = '0; in_if.b_z = '0;
    in_if.p_x = '0; in_if.p_y = '0; in_if.p_z = '0;
    out_if.ready = 1'b0;
    mx = (1 << (COORD_BITS - 1)) - 1;
    mn = -(1 << (COORD_BITS - 1));

    // zero-length segment with the point on it
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1);
    // zero-length segment away from the point
    add_row(256, 0, 0, 256, 0, 0, 256, 768, 0, 1, 0, 768, 1);
    // before A, past B, halfway
    add_row(0, 0, 0, 256, 0, 0, -256, 0, 0, 1, 0, 256, 0);
    add_row(0, 0, 0, 256, 0, 0, 512, 0, 0, 1, PARAM_ONE, 256, 0);
    add_row(0, 0, 0, 256, 0, 0, 128, 256, 0, 1, PARAM_ONE / 2, 256, 0);
    // projection exactly at A and exactly at B, then a point on the segment at a quarter
    add_row(0, 0, 0, 256, 0, 0, 0, 512, 0, 1, 0, 512, 0);
    add_row(0, 0, 0, 256, 0, 0, 256, 512, 0, 1, PARAM_ONE, 512, 0);
    add_row(0, 0, 0, 0, 0, 256, 0, 0, 64, 1, PARAM_ONE / 4, 0, 0);
    // extremes of the coordinates, mixed with small segments
    add_row(mx, mx, mx, mx, mx, mx, mn, mn, mn);
    add_row(mn, mn, mn, mn, mn, mn, mx, mx, mx);
    add_row(mn, mn, mn, mx, mx, mx, 0, 0, 0);
    add_row(mx, mx, mx, mn, mn, mn, mx, mn, mx);
    add_row(mn, mx, mn, mx, mn, mx, mn, mn, mn);
    add_row(mn, 0, 0, mx, 0, 0, 0, mx, mn);
    add_row(mx, 0, mn, mn, mx, 0, 1, -1, 1);
    add_row(0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 1, 1, 1, 1, 0, 0);
    add_row(-1, -1, -1, 1, 1, 1, 0, 0, mx);
    add_row(0, 0, 0, mx, 0, 0, 1, mx, 0);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_query(directed_rows[i].q, directed_rows[i].fixed, directed_rows[i].res);
      maybe_gap(burst_left);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      q = random_query();
      send_query(q, 1'b0, '0);
      maybe_gap(burst_left);
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
